@@ rtl/shbs_pkg.sv @@
`timescale 1ns / 1ps

package shbs_pkg;

    // Default table size; the top level takes it as a parameter.
    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int KIND_W  = 1;
    localparam int SLOT_W  = 10;
    localparam int HIGH_W  = 64;
    localparam int MID_W   = 64;
    localparam int LOW_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int KEY_W   = HIGH_W + MID_W + LOW_W;
    localparam int COUNT_W = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Word kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD   = 1'b0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 1'b1;

    // Register index (paddr[2]).
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [BYTE_W-1:0] etype;
        logic [BYTE_W-1:0] eflags;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_FIN
    } t_state;

endpackage

@@ rtl/shbs_req_if.sv @@
`timescale 1ns / 1ps

interface shbs_req_if;
    logic                            valid;
    logic                            ready;
    logic [shbs_pkg::KIND_W-1:0]     kind;
    logic [shbs_pkg::SLOT_W-1:0]     slot;
    logic [shbs_pkg::HIGH_W-1:0]     key_high;
    logic [shbs_pkg::MID_W-1:0]      key_mid;
    logic [shbs_pkg::LOW_W-1:0]      key_low;
    logic [shbs_pkg::BYTE_W-1:0]     entry_type;
    logic [shbs_pkg::BYTE_W-1:0]     entry_flags;

    modport source (
        output valid, kind, slot, key_high, key_mid, key_low, entry_type, entry_flags,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, key_high, key_mid, key_low, entry_type, entry_flags,
        output ready
    );
endinterface

@@ rtl/shbs_rsp_if.sv @@
`timescale 1ns / 1ps

interface shbs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [shbs_pkg::BYTE_W-1:0]     match_type;
    logic [shbs_pkg::BYTE_W-1:0]     match_flags;

    modport source (
        output valid, found, match_type, match_flags,
        input  ready
    );
    modport sink (
        input  valid, found, match_type, match_flags,
        output ready
    );
endinterface

@@ rtl/sorted_hash_table_binary_search.sv @@
`timescale 1ns / 1ps

// Channel  | Dir | Word                                              | Handshake
// ---------+-----+---------------------------------------------------+------------
// i_req    | in  | kind, slot, key_high/mid/low, entry_type/flags    | valid/ready
// o_rsp    | out | found, match_type, match_flags (lookups only)     | valid/ready
// APB      | in  | entry_count at byte address 0                     | psel/penable
//
// Loads write the table at the accept edge. A lookup makes P halving probes (at most
// floor(log2(span)) + 1, 11 for 1024 entries), each a table read in ST_PROBE and a compare
// on the shared 160-bit comparator in ST_CMP; a miss then passes one more ST_PROBE, and
// ST_FIN loads the result register. Synchronous active-low reset clears control state and
// entry_count, not the table. The next word is taken while a result waits on o_rsp; a
// finished search holds in ST_FIN until the result register is free.

module sorted_hash_table_binary_search #(
    parameter int TABLE_DEPTH = shbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    shbs_req_if.sink                         i_req,
    shbs_rsp_if.source                       o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [shbs_pkg::PADDR_W-1:0]     paddr,
    input  logic [shbs_pkg::PDATA_W-1:0]     pwdata,
    output logic [shbs_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = shbs_pkg::COUNT_W;
    localparam int BW = shbs_pkg::BYTE_W;
    localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

    // ---------------- configuration ----------------
    logic [CW-1:0] r_entry_count;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == shbs_pkg::REG_ENTRY_COUNT);
    assign prdata   = (paddr[2] == shbs_pkg::REG_ENTRY_COUNT)
                    ? shbs_pkg::PDATA_W'(r_entry_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (w_cfg_wr) begin
            r_entry_count <= pwdata[CW-1:0];
        end
    end

    // ---------------- table memory ----------------
    shbs_pkg::t_entry r_mem [TABLE_DEPTH];
    shbs_pkg::t_entry r_rd;
    shbs_pkg::t_entry w_wr_entry;

    shbs_pkg::t_state r_state, n_state;
    logic             w_accept;
    logic             w_load_wr;
    logic [AW-1:0]    w_rd_addr;
    logic [CW-1:0]    w_probe;

    assign w_accept  = i_req.valid && i_req.ready;
    assign w_load_wr = w_accept && (i_req.kind == shbs_pkg::KIND_LOAD)
                    && (17'(i_req.slot) < DEPTH_W);

    assign w_wr_entry.key    = {i_req.key_high, i_req.key_mid, i_req.key_low};
    assign w_wr_entry.etype  = i_req.entry_type;
    assign w_wr_entry.eflags = i_req.entry_flags;

    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            r_mem[AW'(i_req.slot)] <= w_wr_entry;
        end
    end

    // Registered read, issued in ST_PROBE
    assign w_rd_addr = AW'(w_probe);
    always_ff @(posedge i_clk) begin
        if (r_state == shbs_pkg::ST_PROBE) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // ---------------- search sequencer ----------------
    logic [shbs_pkg::KEY_W-1:0] r_key,   n_key;
    logic [CW-1:0]              r_base,  n_base;
    logic [CW-1:0]              r_span,  n_span;
    logic [CW-1:0]              r_probe, n_probe;
    logic                       r_hit,   n_hit;
    logic [BW-1:0]              r_mtype, n_mtype;
    logic [BW-1:0]              r_mflags, n_mflags;
    logic                       r_out_valid, n_out_valid;
    logic                       r_found, n_found;
    logic [BW-1:0]              r_otype, n_otype;
    logic [BW-1:0]              r_oflags, n_oflags;

    logic [CW-1:0] w_span0;
    logic          w_eq;
    logic          w_gt;
    logic          w_out_free;

    // Clamp the searched span to the table size
    assign w_span0 = (17'(r_entry_count) > DEPTH_W) ? CW'(DEPTH_W) : r_entry_count;
    assign w_probe = r_base + (r_span >> 1);

    // Shared comparator: probe key against the entry just read
    assign w_eq = (r_key == r_rd.key);
    assign w_gt = (r_key >  r_rd.key);

    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == shbs_pkg::ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_base      = r_base;
        n_span      = r_span;
        n_probe     = r_probe;
        n_hit       = r_hit;
        n_mtype     = r_mtype;
        n_mflags    = r_mflags;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_otype     = r_otype;
        n_oflags    = r_oflags;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            shbs_pkg::ST_IDLE: begin
                if (w_accept && (i_req.kind == shbs_pkg::KIND_LOOKUP)) begin
                    n_key   = {i_req.key_high, i_req.key_mid, i_req.key_low};
                    n_base  = '0;
                    n_span  = w_span0;
                    n_hit   = 1'b0;
                    n_state = shbs_pkg::ST_PROBE;
                end
            end
            shbs_pkg::ST_PROBE: begin
                if (r_span == '0) begin
                    n_state = shbs_pkg::ST_FIN;
                end else begin
                    n_probe = w_probe;
                    n_state = shbs_pkg::ST_CMP;
                end
            end
            shbs_pkg::ST_CMP: begin
                if (w_eq) begin
                    n_hit    = 1'b1;
                    n_mtype  = r_rd.etype;
                    n_mflags = r_rd.eflags;
                    n_state  = shbs_pkg::ST_FIN;
                end else if (w_gt) begin
                    n_base  = r_probe + CW'(1);
                    n_span  = (r_span - CW'(1)) >> 1;
                    n_state = shbs_pkg::ST_PROBE;
                end else begin
                    n_span  = r_span >> 1;
                    n_state = shbs_pkg::ST_PROBE;
                end
            end
            shbs_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_otype     = r_hit ? r_mtype  : '0;
                    n_oflags    = r_hit ? r_mflags : '0;
                    n_state     = shbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shbs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_base   <= n_base;
        r_span   <= n_span;
        r_probe  <= n_probe;
        r_hit    <= n_hit;
        r_mtype  <= n_mtype;
        r_mflags <= n_mflags;
        r_found  <= n_found;
        r_otype  <= n_otype;
        r_oflags <= n_oflags;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_found;
    assign o_rsp.match_type  = r_otype;
    assign o_rsp.match_flags = r_oflags;

endmodule
